// File: rtl/qoi_enc_pkg.sv
package qoi_enc_pkg;

  localparam int PIX_W         = 24;
  localparam int INDEX_ENTRIES = 64;
  localparam int HASH_W        = $clog2(INDEX_ENTRIES);
  localparam int MAX_RUN       = 62;
  localparam int RUN_W         = 6;
  localparam int JOB_BYTES     = 5;
  localparam int CNT_W         = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = QPTR_W + 1;

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hC0;
  localparam logic [7:0] OP_RGB   = 8'hFE;

  // alpha fixed at 255 folds into a constant term
  localparam logic [HASH_W-1:0] HASH_BIAS = HASH_W'((255 * 11) % INDEX_ENTRIES);

  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
    logic                      frame_last;
  } qoi_enc_job_t;

  function automatic logic [HASH_W-1:0] qoi_hash(input logic [PIX_W-1:0] px);
    logic [HASH_W-1:0] r;
    logic [HASH_W-1:0] g;
    logic [HASH_W-1:0] b;
    r = px[16 +: HASH_W];
    g = px[8 +: HASH_W];
    b = px[0 +: HASH_W];
    return (r * HASH_W'(3)) + (g * HASH_W'(5)) + (b * HASH_W'(7)) + HASH_BIAS;
  endfunction

endpackage

// File: rtl/qoi_enc_front.sv
module qoi_enc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      temporal_mode,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [47:0]               in_data,
  input  logic                      in_first,
  input  logic                      in_last,
  output logic                      job_valid,
  input  logic                      job_ready,
  output qoi_enc_pkg::qoi_enc_job_t job
);
  import qoi_enc_pkg::*;

  logic [PIX_W-1:0]         tbl [INDEX_ENTRIES];
  logic [INDEX_ENTRIES-1:0] entry_vld;
  logic [INDEX_ENTRIES-1:0] entry_vld_next;
  logic [PIX_W-1:0]         last_pixel;
  logic [PIX_W-1:0]         last_pixel_next;
  logic [RUN_W-1:0]         run_count;
  logic [RUN_W-1:0]         run_count_next;

  logic                     s1_valid;
  logic [PIX_W-1:0]         s1_px;
  logic [HASH_W-1:0]        s1_hash;
  logic                     s1_first;
  logic                     s1_last;
  logic [PIX_W-1:0]         s1_rdata;
  logic                     s1_byp_hit;
  logic [PIX_W-1:0]         s1_byp_px;

  logic                     accept;
  logic                     commit;
  logic                     tbl_wr;
  logic [7:0]               vr, vg, vb;
  logic [PIX_W-1:0]         px_in;
  logic [HASH_W-1:0]        hash_in;

  logic [PIX_W-1:0]         lp;
  logic [RUN_W-1:0]         rc;
  logic [RUN_W-1:0]         rc_inc;
  logic [PIX_W-1:0]         entry;
  logic                     eq;
  logic [7:0]               ur, ug, ub, lr, lb;
  logic [3:0][7:0]          m;
  logic [CNT_W-1:0]         mcnt;
  logic [CNT_W-1:0]         job_cnt;

  always_comb begin
    vr = in_data[7:0];
    vg = in_data[15:8];
    vb = in_data[23:16];
    if (temporal_mode) begin
      vr = in_data[31:24] - in_data[7:0];
      vg = in_data[39:32] - in_data[15:8];
      vb = in_data[47:40] - in_data[23:16];
    end
    px_in   = {vr, vg, vb};
    hash_in = qoi_hash(px_in);
  end

  assign accept    = in_valid && in_ready;
  assign commit    = s1_valid && ((job_cnt == '0) || job_ready);
  assign in_ready  = !s1_valid || commit;
  assign job_valid = s1_valid && (job_cnt != '0);

  // classify the pixel held in the front stage
  always_comb begin
    lp     = s1_first ? '0 : last_pixel;
    rc     = s1_first ? '0 : run_count;
    rc_inc = rc + RUN_W'(1);
    if (s1_first || !entry_vld[s1_hash]) begin
      entry = '0;
    end else begin
      entry = s1_byp_hit ? s1_byp_px : s1_rdata;
    end
    eq = (s1_px == lp);
    ur = s1_px[23:16] - lp[23:16];
    ug = s1_px[15:8] - lp[15:8];
    ub = s1_px[7:0] - lp[7:0];
    lr = ur - ug;
    lb = ub - ug;

    m    = '0;
    mcnt = '0;
    if (entry == s1_px) begin
      m[0] = OP_INDEX | {2'b00, s1_hash};
      mcnt = CNT_W'(1);
    end else if ((8'(ur + 8'd2) < 8'd4) && (8'(ug + 8'd2) < 8'd4) &&
                 (8'(ub + 8'd2) < 8'd4)) begin
      m[0] = OP_DIFF | {2'b00, ur[1:0] + 2'd2, ug[1:0] + 2'd2, ub[1:0] + 2'd2};
      mcnt = CNT_W'(1);
    end else if ((8'(lr + 8'd8) < 8'd16) && (8'(ug + 8'd32) < 8'd64) &&
                 (8'(lb + 8'd8) < 8'd16)) begin
      m[0] = OP_LUMA | {2'b00, ug[5:0] + 6'd32};
      m[1] = {lr[3:0] + 4'd8, lb[3:0] + 4'd8};
      mcnt = CNT_W'(2);
    end else begin
      m[0] = OP_RGB;
      m[1] = s1_px[23:16];
      m[2] = s1_px[15:8];
      m[3] = s1_px[7:0];
      mcnt = CNT_W'(4);
    end

    job.bytes       = '0;
    job.frame_last  = s1_last;
    job_cnt         = '0;
    tbl_wr          = 1'b0;
    run_count_next  = rc;
    last_pixel_next = lp;
    if (eq) begin
      run_count_next = rc_inc;
      if ((rc_inc >= RUN_W'(MAX_RUN)) || s1_last) begin
        job.bytes[0]   = OP_RUN | {2'b00, rc_inc - RUN_W'(1)};
        job_cnt        = CNT_W'(1);
        run_count_next = '0;
      end
    end else begin
      run_count_next  = '0;
      last_pixel_next = s1_px;
      tbl_wr          = (entry != s1_px);
      if (rc != '0) begin
        job.bytes[0] = OP_RUN | {2'b00, rc - RUN_W'(1)};
        for (int i = 0; i < 4; i++) begin
          job.bytes[i+1] = m[i];
        end
        job_cnt = mcnt + CNT_W'(1);
      end else begin
        for (int i = 0; i < 4; i++) begin
          job.bytes[i] = m[i];
        end
        job_cnt = mcnt;
      end
    end
    job.cnt = job_cnt;

    entry_vld_next = s1_first ? '0 : entry_vld;
    if (tbl_wr) begin
      entry_vld_next[s1_hash] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && tbl_wr) begin
      tbl[s1_hash] <= s1_px;
    end
    if (accept) begin
      s1_px      <= px_in;
      s1_hash    <= hash_in;
      s1_first   <= in_first;
      s1_last    <= in_last;
      s1_rdata   <= tbl[hash_in];
      // write landing on the same edge as this read
      s1_byp_hit <= commit && tbl_wr && (s1_hash == hash_in);
      s1_byp_px  <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      entry_vld  <= '0;
      last_pixel <= '0;
      run_count  <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (commit) begin
        s1_valid <= 1'b0;
      end
      if (commit) begin
        entry_vld  <= entry_vld_next;
        last_pixel <= last_pixel_next;
        run_count  <= run_count_next;
      end
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst) run_count < RUN_W'(MAX_RUN))
    else $error("run count reached limit without flush");
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && eq |-> job_cnt <= CNT_W'(1))
    else $error("repeat pixel produced more than one byte");
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_byp_hit && !s1_first |-> entry_vld[s1_hash])
    else $error("bypass hit on invalid table entry");
`endif

endmodule

// File: rtl/qoi_enc_queue.sv
module qoi_enc_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  qoi_enc_pkg::qoi_enc_job_t in_job,
  output logic                      out_valid,
  input  logic                      out_ready,
  output qoi_enc_pkg::qoi_enc_job_t out_job
);
  import qoi_enc_pkg::*;

  qoi_enc_job_t      slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/qoi_enc_back.sv
module qoi_enc_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_valid,
  output logic                      job_ready,
  input  qoi_enc_pkg::qoi_enc_job_t job,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic                      out_item_done,
  output logic                      out_frame_end
);
  import qoi_enc_pkg::*;

  logic [CNT_W-1:0] idx;
  logic             load;
  logic             last_of;

  assign load      = job_valid && (!out_valid || out_ready);
  assign last_of   = (idx == (job.cnt - CNT_W'(1)));
  assign job_ready = load && last_of;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= job.bytes[idx];
      out_item_done <= last_of;
      out_frame_end <= last_of && job.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last_of ? '0 : idx + CNT_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst) job_valid |-> job.cnt != '0)
    else $error("empty request reached back end");
  assert property (@(posedge clk) disable iff (rst) job_valid |-> idx < job.cnt)
    else $error("byte index past end of request");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_frame_end |-> out_item_done)
    else $error("frame end on a byte that does not close its pixel");
`endif

endmodule

// File: rtl/qoi_rgb_pixel_encoder_unit.sv
// channel  dir  handshake              payload
// s_*      in   s_tvalid/s_tready      s_tdata pixel pair, s_tuser first, s_tlast last
// m_*      out  m_tvalid/m_tready      m_tdata code byte, m_tuser item done, m_tlast frame end
// cfg_*    in   cfg_valid/cfg_ready    cfg_data temporal mode
//
// One pixel per cycle in unless the request queue is full; one code byte per cycle out while m_tready is high.
// A pixel makes 0 to 5 bytes; the first passes the front stage, the 4-request queue and the output register.
// Index table is a 64x24 memory read at accept; same-hash write-read is bypassed.
// Table clears at frame start through per-entry valid bits; rst is synchronous.
// Input stalls only when the request queue is full.
module qoi_rgb_pixel_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // cur_red, cur_green, cur_blue, ref_red, ref_green, ref_blue
  input  logic        s_tuser,  // frame_first
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // code_byte
  output logic        m_tuser,  // item_done
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import qoi_enc_pkg::*;

  logic         temporal_mode;
  logic         fq_valid;
  logic         fq_ready;
  qoi_enc_job_t fq_job;
  logic         qb_valid;
  logic         qb_ready;
  qoi_enc_job_t qb_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temporal_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      temporal_mode <= cfg_data;
    end
  end

  qoi_enc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .temporal_mode (temporal_mode),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_data       (s_tdata),
    .in_first      (s_tuser),
    .in_last       (s_tlast),
    .job_valid     (fq_valid),
    .job_ready     (fq_ready),
    .job           (fq_job)
  );

  qoi_enc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_job    (fq_job),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_job   (qb_job)
  );

  qoi_enc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (qb_valid),
    .job_ready     (qb_ready),
    .job           (qb_job),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_byte      (m_tdata),
    .out_item_done (m_tuser),
    .out_frame_end (m_tlast)
  );

endmodule

// File: tb/tb_qoi_rgb_pixel_encoder_unit.sv
`timescale 1ns / 1ps

module tb_qoi_rgb_pixel_encoder_unit;
  import qoi_enc_pkg::*;

  localparam int SETTLE_CYCLES = 10;
  localparam int QUIET_LIMIT   = 2000;

  typedef struct packed {
    logic [7:0] code;
    logic       done;
    logic       fend;
  } qoi_code_t;

  class qoi_byte_scoreboard;
    logic [23:0] color_table [INDEX_ENTRIES];
    logic [23:0] prev_px;
    int unsigned run_len;
    bit          diff_mode;
    qoi_code_t   expected_bytes [$];
    int unsigned pixels_seen;
    int unsigned bytes_checked;
    int unsigned mismatches;

    function void clear_frame();
      foreach (color_table[i]) color_table[i] = '0;
      prev_px = '0;
      run_len = 0;
    endfunction

    function void queue_byte(logic [7:0] code);
      qoi_code_t e;
      e.code = code;
      e.done = 1'b0;
      e.fend = 1'b0;
      expected_bytes.push_back(e);
    endfunction

    function void flush_run();
      queue_byte(OP_RUN | {2'b00, 6'(run_len - 1)});
      run_len = 0;
    endfunction

    function void note_pixel(logic [47:0] data, bit first, bit last);
      logic [7:0]        r, g, b, ur, ug, ub;
      logic signed [7:0] dr, dg, db, lr, lb;
      logic [23:0]       px;
      logic [5:0]        h;
      int unsigned       n0;
      qoi_code_t         tail;
      n0 = expected_bytes.size();
      pixels_seen++;
      if (first) clear_frame();
      r = data[7:0];
      g = data[15:8];
      b = data[23:16];
      if (diff_mode) begin
        r = data[31:24] - r;
        g = data[39:32] - g;
        b = data[47:40] - b;
      end
      px = {r, g, b};
      if (px == prev_px) begin
        run_len++;
        if (run_len >= MAX_RUN) flush_run();
      end else begin
        if (run_len > 0) flush_run();
        h = 6'(3 * int'(r) + 5 * int'(g) + 7 * int'(b) + 255 * 11);
        if (color_table[h] == px) begin
          queue_byte(OP_INDEX | {2'b00, h});
        end else begin
          ur = r - prev_px[23:16];
          ug = g - prev_px[15:8];
          ub = b - prev_px[7:0];
          dr = ur;
          dg = ug;
          db = ub;
          lr = ur - ug;
          lb = ub - ug;
          color_table[h] = px;
          if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
            queue_byte(OP_DIFF | {2'b00, 2'(dr + 2), 2'(dg + 2), 2'(db + 2)});
          end else if (lr >= -8 && lr <= 7 && dg >= -32 && dg <= 31 &&
                       lb >= -8 && lb <= 7) begin
            queue_byte(OP_LUMA | {2'b00, 6'(dg + 32)});
            queue_byte({4'(lr + 8), 4'(lb + 8)});
          end else begin
            queue_byte(OP_RGB);
            queue_byte(r);
            queue_byte(g);
            queue_byte(b);
          end
        end
        prev_px = px;
      end
      if (last && run_len > 0) flush_run();
      if (expected_bytes.size() > n0) begin
        tail = expected_bytes.pop_back();
        tail.done = 1'b1;
        tail.fend = last;
        expected_bytes.push_back(tail);
      end
    endfunction

    function void flag(string what, logic [7:0] exp_v, logic [7:0] got_v);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, exp_v, got_v);
    endfunction

    function void check_byte(logic [7:0] code, logic done, logic fend);
      qoi_code_t e;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: stray code byte, expected none, actual %02h done %0b end %0b",
                   $time, code, done, fend);
      end else begin
        e = expected_bytes.pop_front();
        if (code !== e.code) flag("code_byte", e.code, code);
        if (done !== e.done) flag("item_done", 8'(e.done), 8'(done));
        if (fend !== e.fend) flag("frame_end", 8'(e.fend), 8'(fend));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  qoi_byte_scoreboard sb;
  bit          steady;
  int          stall_left;
  int          out_gap;
  int          quiet_cycles;
  int          mode_writes;
  logic [23:0] gen_prev;
  logic [23:0] palette [8];
  logic [2:0]  pal_ptr;
  int unsigned run_left;

  qoi_rgb_pixel_encoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int idle_draw();
    return steady ? 0 : int'($urandom_range(0, 9));
  endfunction

  // random previous-frame pixel; current pixel solved so the coded value is v
  function automatic logic [47:0] pixel_data(logic [23:0] v);
    logic [7:0] pr, pg, pb;
    pr = 8'($urandom);
    pg = 8'($urandom);
    pb = 8'($urandom);
    if (sb.diff_mode)
      return {pb, pg, pr, pb - v[7:0], pg - v[15:8], pr - v[23:16]};
    return {pb, pg, pr, v[7:0], v[15:8], v[23:16]};
  endfunction

  function automatic logic [23:0] next_value();
    logic [7:0] r, g, b;
    int         dg;
    int         pick;
    if (run_left > 0) begin
      run_left--;
      return gen_prev;
    end
    pick = $urandom_range(0, 99);
    r = gen_prev[23:16];
    g = gen_prev[15:8];
    b = gen_prev[7:0];
    if (pick < 30) begin
      run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 6);
      return gen_prev;
    end else if (pick < 45) begin
      return palette[$urandom_range(0, 7)];
    end else if (pick < 65) begin
      r = r + 8'($urandom_range(0, 3)) - 8'd2;
      g = g + 8'($urandom_range(0, 3)) - 8'd2;
      b = b + 8'($urandom_range(0, 3)) - 8'd2;
    end else if (pick < 80) begin
      dg = int'($urandom_range(0, 63)) - 32;
      g = g + 8'(dg);
      r = r + 8'(dg + int'($urandom_range(0, 15)) - 8);
      b = b + 8'(dg + int'($urandom_range(0, 15)) - 8);
    end else if (pick < 95) begin
      return 24'($urandom);
    end else begin
      return '0;
    end
    return {r, g, b};
  endfunction

  task automatic send_pixel(input logic [47:0] data, input bit first, input bit last);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= first;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(data, first, last);
  endtask

  task automatic set_mode(input bit m);
    s_tvalid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    // pending runs give no bytes, so let the pipe empty out
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.diff_mode = m;
    mode_writes++;
  endtask

  task automatic random_frames(input int unsigned n_items);
    int unsigned flen;
    logic [23:0] v;
    bit          first, last;
    while (n_items > 0) begin
      flen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      if (flen > n_items) flen = n_items;
      steady = ($urandom_range(0, 4) == 0);
      for (int unsigned i = 0; i < flen; i++) begin
        first = (i == 0) && ($urandom_range(0, 9) != 0);
        last  = (i == flen - 1) && ($urandom_range(0, 7) != 0);
        if (first) gen_prev = '0;
        v = next_value();
        send_pixel(pixel_data(v), first, last);
        gen_prev = v;
        palette[pal_ptr] = v;
        pal_ptr++;
      end
      n_items -= flen;
    end
  endtask

  task automatic long_run();
    logic [23:0] v;
    v = 24'($urandom) | 24'h1;
    steady = 1'b0;
    // 70 equal pixels: one code, a run hitting the limit, then a flushed tail
    for (int i = 0; i < 70; i++) send_pixel(pixel_data(v), i == 0, i == 69);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      sb.check_byte(m_tdata, m_tuser, m_tlast);
      out_gap     = idle_draw();
      stall_left <= (out_gap > 0) ? out_gap - 1 : 0;
      m_tready   <= (out_gap == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("qoi_rgb_pixel_encoder_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new;
    sb.clear_frame();
    steady = 1'b0;
    gen_prev = '0;
    pal_ptr = '0;
    run_left = 0;
    mode_writes = 0;
    foreach (palette[i]) palette[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_mode(1'b0);
    send_pixel(pixel_data(24'h000000), 1'b1, 1'b0);  // black matches cleared last pixel
    send_pixel(pixel_data(24'h000000), 1'b0, 1'b0);
    send_pixel(pixel_data(24'h0100FF), 1'b0, 1'b0);
    send_pixel(pixel_data(24'hFFFFFF), 1'b0, 1'b0);
    send_pixel(pixel_data(24'h000000), 1'b0, 1'b0);  // cleared slot hit
    send_pixel(pixel_data(24'h14191E), 1'b0, 1'b0);
    send_pixel(pixel_data(24'hC80A64), 1'b0, 1'b0);
    send_pixel(pixel_data(24'h0100FF), 1'b0, 1'b0);
    send_pixel(pixel_data(24'h0100FF), 1'b0, 1'b0);
    send_pixel(pixel_data(24'h0100FF), 1'b0, 1'b1);
    send_pixel(pixel_data(24'h000000), 1'b1, 1'b1);  // first and last together
    send_pixel(pixel_data(24'h808080), 1'b1, 1'b1);
    send_pixel(pixel_data(24'h7F7F7F), 1'b1, 1'b0);
    send_pixel(pixel_data(24'h7F7F7F), 1'b0, 1'b0);
    send_pixel(pixel_data(24'h7F7F7F), 1'b0, 1'b0);
    send_pixel(pixel_data(24'h000000), 1'b1, 1'b0);  // run dropped, no frame end
    send_pixel(pixel_data(24'h010101), 1'b0, 1'b1);

    set_mode(1'b1);
    send_pixel({8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 1'b0);
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b0);
    send_pixel({8'h56, 8'h34, 8'h12, 8'h56, 8'h34, 8'h12}, 1'b0, 1'b0);
    send_pixel({8'h80, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h01}, 1'b0, 1'b1);

    long_run();
    random_frames(30);
    set_mode(1'b0);
    random_frames(30);
    set_mode(1'b1);
    random_frames(30);

    s_tvalid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d pixels, %0d code bytes, %0d mode writes in direct and temporal coding",
             sb.pixels_seen, sb.bytes_checked, mode_writes);
    $display("including run limit, dropped runs, single-pixel frames and cleared-slot hits");
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("qoi_rgb_pixel_encoder_unit verification clean");
    end else begin
      $display("%0d mismatches, %0d bytes never seen", sb.mismatches, sb.expected_bytes.size());
      $display("qoi_rgb_pixel_encoder_unit verification failed");
    end
    $finish;
  end

endmodule
